### hdl/rc4_stream_cipher_macros.svh
// assertion macros for the rc4 stream cipher
// no dependencies; expects clock and reset in the including scope
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

`ifndef SYNTH
`define RC4_ASSERT_HOLD(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rc4 same-cycle check failed");
`define RC4_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rc4 next-cycle check failed");
`else
`define RC4_ASSERT_HOLD(label, ante, cons)
`define RC4_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/rc4_pkg.sv
// shared constants and types for the rc4 stream cipher
// no dependencies
`timescale 1ns / 1ps

package rc4_pkg;

   localparam int MAX_KEY_BYTES_DEF = 32;
   localparam int BYTE_W            = 8;
   localparam int SBOX_DEPTH        = 256;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 64;
   localparam int KEY_LEN_W         = 6;
   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_LENGTH = 3'd0,
      CSR_KEY_WORD0  = 3'd1,
      CSR_KEY_WORD1  = 3'd2,
      CSR_KEY_WORD2  = 3'd3,
      CSR_KEY_WORD3  = 3'd4
   } csr_index_type;

endpackage

### hdl/rc4_stream_cipher.sv
// RC4 stream cipher, one data byte in and one result byte out per beat. The
// S-box lives in a single 256 x 8 memory with one write and one registered read
// port. The first beat of a message (and the first beat after one carrying
// req_last_byte) first rebuilds the S-box: an identity fill, then the key
// schedule, each step reading S[j], writing S[j], then writing S[i] while
// reading the next S[i]. After that each byte steps through read S[j], write
// S[j], write S[i] while reading the keystream entry, then the result, which
// waits while an earlier result is still held by rsp_ready low; the next beat
// is taken in that result step. The single memory port sets this sequence.
// Key registers are sampled by the next key schedule only.
// Depends on rc4_pkg, rc4_key_regs and rc4_stream_cipher_macros.svh.
`timescale 1ns / 1ps
`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher #(
   parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rc4_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rc4_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_out_last,
   input  logic                            csr_write_en,
   input  logic [rc4_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rc4_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int BW     = rc4_pkg::BYTE_W;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_KS_INIT = 9'b000000010,
      ST_KS_RDJ  = 9'b000000100,
      ST_KS_WRJ  = 9'b000001000,
      ST_KS_WRN  = 9'b000010000,
      ST_P_RDJ   = 9'b000100000,
      ST_P_WRJ   = 9'b001000000,
      ST_P_WRI   = 9'b010000000,
      ST_P_OUT   = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [BW-1:0]     n_ff, n_in;
   logic [KIDX_W-1:0] kidx_ff, kidx_in;
   logic [BW-1:0]     i_ff, i_in;
   logic [BW-1:0]     j_ff, j_in;
   logic [BW-1:0]     sa_ff, sa_in;
   logic [BW-1:0]     sb_ff, sb_in;
   logic              fwd_ff, fwd_in;
   logic              keyed_ff, keyed_in;
   logic [BW-1:0]     data_ff, data_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]     rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [BW-1:0]     sbox_mem [rc4_pkg::SBOX_DEPTH];
   logic [BW-1:0]     rd_data_ff;
   logic              mem_we, mem_re;
   logic [BW-1:0]     mem_waddr, mem_wdata, mem_raddr;

   logic [BW-1:0]     key_byte;
   logic [KIDX_W-1:0] key_last_index;
   logic              out_free;
   logic              keyed_now;
   logic [BW-1:0]     j_step;
   logic [BW-1:0]     k_addr;
   logic [BW-1:0]     key_stream;

   rc4_key_regs #(
      .MAX_KEY_BYTES(MAX_KEY_BYTES)
   ) u_key_regs (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data),
      .key_index     (kidx_ff),
      .key_byte      (key_byte),
      .key_last_index(key_last_index)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sbox_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= sbox_mem[mem_raddr];
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign key_stream = fwd_ff ? sb_ff : rd_data_ff;
   assign k_addr     = sa_ff + sb_ff;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      kidx_in      = kidx_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      fwd_in       = fwd_ff;
      keyed_in     = keyed_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      req_ready    = 1'b0;
      keyed_now    = keyed_ff;
      j_step       = j_ff + rd_data_ff + key_byte;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_KS_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = n_ff;
            mem_wdata = n_ff;
            n_in      = n_ff + 8'd1;
            if (n_ff == 8'hFF) begin
               mem_re    = 1'b1;
               mem_raddr = '0;
               kidx_in   = '0;
               j_in      = '0;
               state_in  = ST_KS_RDJ;
            end
         end
         ST_KS_RDJ: begin
            sa_in     = rd_data_ff;
            j_in      = j_step;
            mem_re    = 1'b1;
            mem_raddr = j_step;
            kidx_in   = (kidx_ff == key_last_index) ? '0 : kidx_ff + KIDX_W'(1);
            state_in  = ST_KS_WRJ;
         end
         ST_KS_WRJ: begin
            sb_in     = rd_data_ff;
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = sa_ff;
            state_in  = ST_KS_WRN;
         end
         ST_KS_WRN: begin
            mem_we    = 1'b1;
            mem_waddr = n_ff;
            mem_wdata = sb_ff;
            mem_re    = 1'b1;
            if (n_ff == 8'hFF) begin
               // schedule done: first byte reads S[1]
               mem_raddr = 8'd1;
               i_in      = 8'd1;
               j_in      = '0;
               n_in      = '0;
               keyed_in  = 1'b1;
               state_in  = ST_P_RDJ;
            end else begin
               mem_raddr = n_ff + 8'd1;
               n_in      = n_ff + 8'd1;
               state_in  = ST_KS_RDJ;
            end
         end
         ST_P_RDJ: begin
            sa_in     = rd_data_ff;
            j_in      = j_ff + rd_data_ff;
            mem_re    = 1'b1;
            mem_raddr = j_ff + rd_data_ff;
            state_in  = ST_P_WRJ;
         end
         ST_P_WRJ: begin
            sb_in     = rd_data_ff;
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = sa_ff;
            state_in  = ST_P_WRI;
         end
         ST_P_WRI: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = sb_ff;
            mem_re    = 1'b1;
            mem_raddr = k_addr;
            // read of S[i] in the cycle it is written
            fwd_in    = (k_addr == i_ff);
            state_in  = ST_P_OUT;
         end
         ST_P_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = data_ff ^ key_stream;
               rsp_last_in  = last_ff;
               keyed_now    = keyed_ff && !last_ff;
               keyed_in     = keyed_ff && !last_ff;
               req_ready    = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (req_valid && req_ready) begin
         data_in = req_data_byte;
         last_in = req_last_byte;
         if (keyed_now) begin
            i_in      = i_ff + 8'd1;
            mem_re    = 1'b1;
            mem_raddr = i_ff + 8'd1;
            state_in  = ST_P_RDJ;
         end else begin
            n_in     = '0;
            state_in = ST_KS_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         kidx_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         keyed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         kidx_ff      <= kidx_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         keyed_ff     <= keyed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      fwd_ff      <= fwd_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

   `RC4_ASSERT_HOLD(a_prga_keyed, state_ff == ST_P_RDJ, keyed_ff)
   `RC4_ASSERT_NEXT(a_sched_done, state_ff == ST_KS_WRN && n_ff == 8'hFF, keyed_ff && i_ff == 8'd1 && j_ff == 8'd0)
   `RC4_ASSERT_NEXT(a_last_unkeys, state_ff == ST_P_OUT && out_free && last_ff, !keyed_ff)

endmodule

### hdl/rc4_key_regs.sv
// key length and key byte registers, effective length and key byte select
// depends on rc4_pkg
`timescale 1ns / 1ps

module rc4_key_regs #(
   parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF,
   localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [rc4_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rc4_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic [KIDX_W-1:0]               key_index,
   output logic [rc4_pkg::BYTE_W-1:0]      key_byte,
   output logic [KIDX_W-1:0]               key_last_index
);

   logic [rc4_pkg::KEY_LEN_W-1:0] key_len_ff;
   logic [rc4_pkg::BYTE_W-1:0]    key_bytes_ff [MAX_KEY_BYTES];
   logic                          word_we;
   logic [1:0]                    word_sel;
   logic [rc4_pkg::KEY_LEN_W-1:0] key_len_eff;

   assign word_we  = csr_write_en
                     && (csr_index >= rc4_pkg::CSR_KEY_WORD0)
                     && (csr_index <= rc4_pkg::CSR_KEY_WORD3);
   assign word_sel = 2'(csr_index - rc4_pkg::CSR_KEY_WORD0);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff <= rc4_pkg::KEY_LEN_RESET;
         for (int b = 0; b < MAX_KEY_BYTES; b++) begin
            key_bytes_ff[b] <= '0;
         end
      end else begin
         if (csr_write_en && csr_index == rc4_pkg::CSR_KEY_LENGTH) begin
            key_len_ff <= csr_write_data[rc4_pkg::KEY_LEN_W-1:0];
         end
         for (int b = 0; b < MAX_KEY_BYTES; b++) begin
            if (word_we && word_sel == 2'(b >> 3)) begin
               key_bytes_ff[b] <= csr_write_data[8*(b & 7) +: rc4_pkg::BYTE_W];
            end
         end
      end
   end

   // zero length acts as one, longer than the store saturates
   always_comb begin
      if (key_len_ff == '0) begin
         key_len_eff = rc4_pkg::KEY_LEN_W'(1);
      end else if (key_len_ff > rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES)) begin
         key_len_eff = rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES);
      end else begin
         key_len_eff = key_len_ff;
      end
   end

   assign key_last_index = KIDX_W'(key_len_eff - rc4_pkg::KEY_LEN_W'(1));
   assign key_byte       = key_bytes_ff[key_index];

endmodule

### dv/rc4_stream_cipher_tb.sv
// self-checking testbench for rc4_stream_cipher: directed and random messages, random key setups
// depends on rc4_pkg and the rc4_stream_cipher rtl; predicts each beat with its own rc4 engine
`timescale 1ns / 1ps

module rc4_stream_cipher_tb;

   localparam int RANDOM_BEATS = 1650;
   localparam logic [rc4_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO =
      rc4_pkg::CSR_INDEX_W'(rc4_pkg::CSR_KEY_WORD3) + 1'b1;
   localparam logic [rc4_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = {rc4_pkg::CSR_INDEX_W{1'b1}};

   typedef struct packed {
      logic [rc4_pkg::BYTE_W-1:0] out_byte;
      logic                       out_last;
   } cipher_beat_type;

   class rc4_scoreboard;
      logic [rc4_pkg::BYTE_W-1:0]     sbox [rc4_pkg::SBOX_DEPTH];
      logic [rc4_pkg::BYTE_W-1:0]     idx_i;
      logic [rc4_pkg::BYTE_W-1:0]     idx_j;
      bit                             keyed;
      logic [rc4_pkg::KEY_LEN_W-1:0]  key_len;
      logic [rc4_pkg::CSR_DATA_W-1:0] key_word [4];
      cipher_beat_type                expected_beats [$];
      int                             mismatches;

      function new();
         idx_i = '0;
         idx_j = '0;
         keyed = 1'b0;
         key_len = rc4_pkg::KEY_LEN_RESET;
         foreach (key_word[w]) key_word[w] = '0;
         foreach (sbox[n]) sbox[n] = '0;
         mismatches = 0;
      endfunction

      function void note_config(logic [rc4_pkg::CSR_INDEX_W-1:0] idx,
                                logic [rc4_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            rc4_pkg::CSR_KEY_LENGTH: key_len = value[rc4_pkg::KEY_LEN_W-1:0];
            rc4_pkg::CSR_KEY_WORD0:  key_word[0] = value;
            rc4_pkg::CSR_KEY_WORD1:  key_word[1] = value;
            rc4_pkg::CSR_KEY_WORD2:  key_word[2] = value;
            rc4_pkg::CSR_KEY_WORD3:  key_word[3] = value;
            default: ;
         endcase
      endfunction

      function void run_schedule();
         int len;
         int k;
         logic [rc4_pkg::BYTE_W-1:0] j;
         logic [rc4_pkg::BYTE_W-1:0] t;
         len = key_len;
         if (len == 0) len = 1;
         if (len > rc4_pkg::MAX_KEY_BYTES_DEF) len = rc4_pkg::MAX_KEY_BYTES_DEF;
         for (int n = 0; n < rc4_pkg::SBOX_DEPTH; n++) sbox[n] = rc4_pkg::BYTE_W'(n);
         j = '0;
         for (int n = 0; n < rc4_pkg::SBOX_DEPTH; n++) begin
            k = n % len;
            j = j + sbox[n] + key_word[k / 8][(k % 8) * 8 +: 8];
            t = sbox[j];
            sbox[j] = sbox[n];
            sbox[n] = t;
         end
         idx_i = '0;
         idx_j = '0;
         keyed = 1'b1;
      endfunction

      function void note_byte_in(logic [rc4_pkg::BYTE_W-1:0] data, logic last);
         logic [rc4_pkg::BYTE_W-1:0] t;
         logic [rc4_pkg::BYTE_W-1:0] ks_idx;
         cipher_beat_type beat;
         if (!keyed) run_schedule();
         idx_i = idx_i + 1'b1;
         idx_j = idx_j + sbox[idx_i];
         t = sbox[idx_j];
         sbox[idx_j] = sbox[idx_i];
         sbox[idx_i] = t;
         ks_idx = sbox[idx_i] + sbox[idx_j];
         beat.out_byte = data ^ sbox[ks_idx];
         beat.out_last = last;
         expected_beats.push_back(beat);
         if (last) keyed = 1'b0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
      endfunction

      function void check_byte_out(logic [rc4_pkg::BYTE_W-1:0] out_byte, logic out_last);
         cipher_beat_type exp_beat;
         if (expected_beats.size() == 0) begin
            flag($sformatf("unexpected beat byte=%02h last=%0b", out_byte, out_last));
            return;
         end
         exp_beat = expected_beats.pop_front();
         if (out_byte !== exp_beat.out_byte)
            flag($sformatf("out_byte expected %02h actual %02h", exp_beat.out_byte, out_byte));
         if (out_last !== exp_beat.out_last)
            flag($sformatf("out_last expected %0b actual %0b", exp_beat.out_last, out_last));
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [rc4_pkg::BYTE_W-1:0]      req_data_byte = '0;
   logic                            req_last_byte = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b1;
   logic [rc4_pkg::BYTE_W-1:0]      rsp_out_byte;
   logic                            rsp_out_last;
   logic                            csr_write_en = 1'b0;
   logic [rc4_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [rc4_pkg::CSR_DATA_W-1:0]  csr_write_data = '0;

   rc4_scoreboard sb;
   bit idle_on = 1'b1;
   int beats_sent = 0;

   rc4_stream_cipher dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_byte(input logic [rc4_pkg::BYTE_W-1:0] data, input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_byte_in(data, last);
      beats_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.expected_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [rc4_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rc4_pkg::CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      sb.note_config(idx, value);
      @(posedge clock);
   endtask

   function automatic logic [rc4_pkg::CSR_DATA_W-1:0] rand_word();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready)
            sb.check_byte_out(rsp_out_byte, rsp_out_last);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= (stall_left == 0);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      int phase_beats;
      int msg_left;
      logic [rc4_pkg::CSR_DATA_W-1:0] len_val;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset key, single-byte message
      send_byte(8'h00, 1'b1);
      drain_results();

      // one-byte key
      csr_write(rc4_pkg::CSR_KEY_LENGTH, 64'd1);
      csr_write(rc4_pkg::CSR_KEY_WORD0, 64'h0000_0000_0000_00ff);
      csr_write_en <= 1'b0;
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h5a, 1'b1);
      drain_results();

      // zero length with upper bits set, treated as one
      csr_write(rc4_pkg::CSR_KEY_LENGTH, 64'hffff_ffff_ffff_ffc0);
      csr_write(rc4_pkg::CSR_KEY_WORD0, {$urandom, $urandom});
      csr_write_en <= 1'b0;
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      drain_results();

      // full 32-byte key, all ones
      csr_write(rc4_pkg::CSR_KEY_LENGTH, 64'd32);
      csr_write(rc4_pkg::CSR_KEY_WORD0, '1);
      csr_write(rc4_pkg::CSR_KEY_WORD1, '1);
      csr_write(rc4_pkg::CSR_KEY_WORD2, '1);
      csr_write(rc4_pkg::CSR_KEY_WORD3, '1);
      csr_write_en <= 1'b0;
      send_byte(8'hff, 1'b0);
      send_byte(8'h7f, 1'b1);
      drain_results();

      // oversize length saturates, writes past the register list are dropped
      csr_write(rc4_pkg::CSR_KEY_LENGTH, 64'd63);
      csr_write(rc4_pkg::CSR_KEY_WORD0, {$urandom, $urandom});
      csr_write(rc4_pkg::CSR_KEY_WORD1, {$urandom, $urandom});
      csr_write(rc4_pkg::CSR_KEY_WORD2, {$urandom, $urandom});
      csr_write(rc4_pkg::CSR_KEY_WORD3, {$urandom, $urandom});
      for (int idx = CSR_SPARE_LO; idx <= CSR_SPARE_HI; idx++)
         csr_write(rc4_pkg::CSR_INDEX_W'(idx), {$urandom, $urandom});
      csr_write_en <= 1'b0;
      send_byte(8'h33, 1'b0);
      send_byte(8'hcc, 1'b1);
      drain_results();

      // key change in mid-message only takes effect on the next message
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      drain_results();
      csr_write(rc4_pkg::CSR_KEY_LENGTH, 64'd5);
      csr_write(rc4_pkg::CSR_KEY_WORD0, {$urandom, $urandom});
      csr_write_en <= 1'b0;
      send_byte(8'h78, 1'b1);
      send_byte(8'h9a, 1'b1);
      drain_results();

      msg_left = 0;
      beats_sent = 0;
      while (beats_sent < RANDOM_BEATS) begin
         idle_on = (beats_sent < RANDOM_BEATS * 9 / 10) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 4))
               0:       len_val = 64'd0;
               1:       len_val = 64'd1;
               2:       len_val = 64'd32;
               3:       len_val = 64'd63;
               default: len_val = 64'($urandom_range(0, 63));
            endcase
            csr_write(rc4_pkg::CSR_KEY_LENGTH, {$urandom, $urandom} & ~64'h3f | len_val);
         end
         if ($urandom_range(0, 1)) csr_write(rc4_pkg::CSR_KEY_WORD0, rand_word());
         if ($urandom_range(0, 1)) csr_write(rc4_pkg::CSR_KEY_WORD1, rand_word());
         if ($urandom_range(0, 1)) csr_write(rc4_pkg::CSR_KEY_WORD2, rand_word());
         if ($urandom_range(0, 1)) csr_write(rc4_pkg::CSR_KEY_WORD3, rand_word());
         if ($urandom_range(0, 7) == 0)
            csr_write(rc4_pkg::CSR_INDEX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)),
                      {$urandom, $urandom});
         csr_write_en <= 1'b0;
         phase_beats = $urandom_range(10, 80);
         repeat (phase_beats) begin
            if (msg_left == 0)
               msg_left = ($urandom_range(0, 11) == 0) ? $urandom_range(257, 300)
                                                       : $urandom_range(1, 24);
            send_byte(rc4_pkg::BYTE_W'($urandom_range(0, 255)), msg_left == 1);
            msg_left--;
         end
         drain_results();
      end

      if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
